// ===== rtl/lh_pkg.sv =====
// ----------------------------------------------------------------------------
// lh_pkg
// Shared constants, codes and types of the luminance histogram.
// ----------------------------------------------------------------------------
`default_nettype none

package lh_pkg;

    localparam int BIN_COUNT   = 65536;
    localparam int IDX_W       = $clog2(BIN_COUNT);

    localparam int SAMPLE_W    = 20;
    localparam int WEIGHT_W    = 16;
    localparam int BIN_W       = 16;
    localparam int COUNT_W     = 32;
    localparam int PROD_W      = SAMPLE_W + WEIGHT_W;
    localparam int SUM_W       = PROD_W + 2;
    localparam int FRAC_SHIFT  = 20;
    localparam int Y_W         = SUM_W - FRAC_SHIFT;
    localparam int CFG_INDEX_W = 8;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [COUNT_W-1:0]  COUNT_MAX = '1;
    localparam logic [Y_W-1:0]      Y_TOP     = Y_W'(BIN_COUNT - 1);
    localparam logic [IDX_W-1:0]    IDX_LAST  = IDX_W'(BIN_COUNT - 1);

    localparam logic [WEIGHT_W-1:0] WEIGHT_RED_RESET   = 16'd18877;
    localparam logic [WEIGHT_W-1:0] WEIGHT_GREEN_RESET = 16'd46653;
    localparam logic [WEIGHT_W-1:0] WEIGHT_BLUE_RESET  = 16'd6;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ACCUM = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WEIGHT_RED   = 8'd0,
        REG_WEIGHT_GREEN = 8'd1,
        REG_WEIGHT_BLUE  = 8'd2
    } t_reg;

    // ZERO: result with zero count, no memory access (unused op, read past end)
    typedef enum logic [1:0] {
        CMD_CLEAR,
        CMD_ACCUM,
        CMD_READ,
        CMD_ZERO
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind        kind;
        logic [BIN_W-1:0] bin;
        logic             eof;
    } t_cmd;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH
    } t_back_state;

endpackage

`default_nettype wire

// ===== rtl/lh_channels.sv =====
// ----------------------------------------------------------------------------
// lh_channels
// Valid/ready channel interfaces: pixel input, configuration write, result.
// ----------------------------------------------------------------------------
`default_nettype none

interface lh_pix_if import lh_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [1:0]          operation;
    logic [SAMPLE_W-1:0] red_sample;
    logic [SAMPLE_W-1:0] green_sample;
    logic [SAMPLE_W-1:0] blue_sample;
    logic [BIN_W-1:0]    read_bin;
    logic                end_of_frame;

    modport source (output valid, operation, red_sample, green_sample, blue_sample,
                    read_bin, end_of_frame, input ready);
    modport sink   (input valid, operation, red_sample, green_sample, blue_sample,
                    read_bin, end_of_frame, output ready);
endinterface

interface lh_cfg_if import lh_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [WEIGHT_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

interface lh_bin_if import lh_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [BIN_W-1:0]   bin_index;
    logic [COUNT_W-1:0] bin_count;
    logic               frame_done;
    logic               count_saturated;

    modport source (output valid, bin_index, bin_count, frame_done, count_saturated,
                    input ready);
    modport sink   (input valid, bin_index, bin_count, frame_done, count_saturated,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/lh_front.sv =====
// ----------------------------------------------------------------------------
// lh_front
// Weight registers, luminance computation and command classification.
// ----------------------------------------------------------------------------
`default_nettype none

module lh_front import lh_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lh_pix_if.sink    i_pix,
    lh_cfg_if.sink    i_cfg,
    output t_cmd      o_cmd,
    output logic      o_cmd_valid,
    input  wire logic i_cmd_ready
);

    logic [WEIGHT_W-1:0] r_weight_red;
    logic [WEIGHT_W-1:0] r_weight_green;
    logic [WEIGHT_W-1:0] r_weight_blue;

    logic                r_s1_valid;
    logic [PROD_W-1:0]   r_prod_red;
    logic [PROD_W-1:0]   r_prod_green;
    logic [PROD_W-1:0]   r_prod_blue;
    logic [1:0]          r_s1_op;
    logic [BIN_W-1:0]    r_s1_bin;
    logic                r_s1_eof;

    logic                accept;
    logic                push;
    logic [SUM_W-1:0]    sum;
    logic [Y_W-1:0]      luma;
    logic [Y_W-1:0]      luma_bin;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight_red   <= WEIGHT_RED_RESET;
            r_weight_green <= WEIGHT_GREEN_RESET;
            r_weight_blue  <= WEIGHT_BLUE_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_WEIGHT_RED:   r_weight_red   <= i_cfg.data;
                REG_WEIGHT_GREEN: r_weight_green <= i_cfg.data;
                REG_WEIGHT_BLUE:  r_weight_blue  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign push        = r_s1_valid && i_cmd_ready;
    assign i_pix.ready = !r_s1_valid || i_cmd_ready;
    assign accept      = i_pix.valid && i_pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (push) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prod_red   <= PROD_W'(i_pix.red_sample)   * PROD_W'(r_weight_red);
            r_prod_green <= PROD_W'(i_pix.green_sample) * PROD_W'(r_weight_green);
            r_prod_blue  <= PROD_W'(i_pix.blue_sample)  * PROD_W'(r_weight_blue);
            r_s1_op      <= i_pix.operation;
            r_s1_bin     <= i_pix.read_bin;
            r_s1_eof     <= i_pix.end_of_frame;
        end
    end

    assign sum      = SUM_W'(r_prod_red) + SUM_W'(r_prod_green) + SUM_W'(r_prod_blue);
    assign luma     = sum[SUM_W-1:FRAC_SHIFT];
    assign luma_bin = (luma > Y_TOP) ? Y_TOP : luma;

    always_comb begin
        o_cmd_valid = r_s1_valid;
        o_cmd.kind  = CMD_ZERO;
        o_cmd.bin   = '0;
        o_cmd.eof   = 1'b0;
        unique case (r_s1_op)
            OP_CLEAR: begin
                o_cmd.kind = CMD_CLEAR;
            end
            OP_ACCUM: begin
                o_cmd.kind = CMD_ACCUM;
                o_cmd.bin  = luma_bin[BIN_W-1:0];
                o_cmd.eof  = r_s1_eof;
            end
            OP_READ: begin
                o_cmd.bin  = r_s1_bin;
                o_cmd.kind = ({1'b0, r_s1_bin} < (BIN_W+1)'(BIN_COUNT)) ? CMD_READ : CMD_ZERO;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/lh_queue.sv =====
// ----------------------------------------------------------------------------
// lh_queue
// Short command queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module lh_queue import lh_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_data,
    output logic      o_ready,
    output logic      o_valid,
    output t_cmd      o_data,
    input  wire logic i_pop
);

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_ready = (r_count != (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lh_back.sv =====
// ----------------------------------------------------------------------------
// lh_back
// Bin memory, clearing sweep, read-modify-write and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lh_back import lh_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_valid,
    input  wire t_cmd i_cmd,
    output logic      o_cmd_pop,
    lh_bin_if.source  o_bin
);

    logic [COUNT_W-1:0] r_mem [BIN_COUNT];
    logic [COUNT_W-1:0] r_rd_data;

    t_back_state        r_state;
    t_back_state        n_state;
    logic [IDX_W-1:0]   r_clr_addr;
    logic [IDX_W-1:0]   n_clr_addr;
    t_cmd               r_cmd;

    logic               r_out_valid;
    logic [BIN_W-1:0]   r_out_index;
    logic [COUNT_W-1:0] r_out_count;
    logic               r_out_done;
    logic               r_out_sat;

    logic               slot_free;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [COUNT_W-1:0] mem_wdata;
    logic [COUNT_W-1:0] count_inc;
    logic               load_out;
    logic [BIN_W-1:0]   n_out_index;
    logic [COUNT_W-1:0] n_out_count;
    logic               n_out_done;
    logic               n_out_sat;

    assign slot_free = !r_out_valid || o_bin.ready;
    assign count_inc = (r_rd_data == COUNT_MAX) ? r_rd_data : r_rd_data + 1'b1;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == IDX_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid && slot_free) begin
                    unique case (i_cmd.kind) inside
                        CMD_CLEAR:           n_state = S_CLEAR;
                        CMD_ACCUM, CMD_READ: n_state = S_FETCH;
                        default:             n_state = S_IDLE;
                    endcase
                end
            end
            S_FETCH: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_pop   = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_clr_addr;
        mem_wdata   = '0;
        n_clr_addr  = r_clr_addr;
        load_out    = 1'b0;
        n_out_index = '0;
        n_out_count = '0;
        n_out_done  = 1'b0;
        n_out_sat   = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                mem_we     = 1'b1;
                n_clr_addr = r_clr_addr + 1'b1;
            end
            S_IDLE: begin
                if (i_cmd_valid && slot_free) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.kind == CMD_CLEAR) begin
                        load_out   = 1'b1;
                        n_clr_addr = '0;
                    end else if (i_cmd.kind == CMD_ZERO) begin
                        load_out    = 1'b1;
                        n_out_index = i_cmd.bin;
                    end
                end
            end
            S_FETCH: begin
                load_out    = 1'b1;
                n_out_index = r_cmd.bin;
                if (r_cmd.kind == CMD_ACCUM) begin
                    mem_we      = 1'b1;
                    mem_waddr   = r_cmd.bin[IDX_W-1:0];
                    mem_wdata   = count_inc;
                    n_out_count = count_inc;
                    n_out_done  = r_cmd.eof;
                    n_out_sat   = (count_inc == COUNT_MAX);
                end else begin
                    n_out_count = r_rd_data;
                    n_out_sat   = (r_rd_data == COUNT_MAX);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[i_cmd.bin[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_bin.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_index <= n_out_index;
            r_out_count <= n_out_count;
            r_out_done  <= n_out_done;
            r_out_sat   <= n_out_sat;
        end
    end

    assign o_bin.valid           = r_out_valid;
    assign o_bin.bin_index       = r_out_index;
    assign o_bin.bin_count       = r_out_count;
    assign o_bin.frame_done      = r_out_done;
    assign o_bin.count_saturated = r_out_sat;

`ifndef NO_ASSERTIONS
    a_fetch_slot_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FETCH |-> !r_out_valid)
        else $error("result slot busy during fetch");

    a_fetch_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FETCH |=> r_out_valid)
        else $error("fetch produced no result");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> (r_state == S_IDLE && i_cmd_valid))
        else $error("command popped outside idle");

    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_sat) |-> (r_out_count == COUNT_MAX))
        else $error("saturated flag without maximum count");
`endif

endmodule

`default_nettype wire

// ===== rtl/luminance_histogram.sv =====
// ----------------------------------------------------------------------------
// luminance_histogram
// Luminance histogram over weighted RGB with programmable weights.
// ----------------------------------------------------------------------------
// Channels: i_pix carries one operation per transaction (clear, accumulate
// pixel, read bin); o_bin returns exactly one result per input transaction,
// in order. i_cfg writes the three Q0.16 weights (index 0 red, 1 green,
// 2 blue); it is always ready and should be used only while the block idles.
// Path: front stage register, command queue, back; clear and unused codes
// load the result when popped, accumulate and read from the fetch state.
// Throughput: unused codes one a cycle while o_bin is ready; the back takes
// no new command until an accumulate or read has done its read-modify-write
// of the bin memory. A clear returns its result when issued and then sweeps
// the memory, one bin a cycle, over all BIN_COUNT bins.
// Reset: weights return to their defaults and a clearing sweep over all
// BIN_COUNT bins (65536) runs; inputs queue meanwhile but are not executed.
// Back-pressure: the result register holds while o_bin is stalled; the
// front keeps accepting until its stage and the command queue fill.
// ----------------------------------------------------------------------------
`default_nettype none

module luminance_histogram import lh_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lh_pix_if.sink    i_pix,
    lh_cfg_if.sink    i_cfg,
    lh_bin_if.source  o_bin
);

    t_cmd front_cmd;
    logic front_valid;
    logic queue_ready;
    t_cmd queue_cmd;
    logic queue_valid;
    logic back_pop;

    lh_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (i_pix),
        .i_cfg       (i_cfg),
        .o_cmd       (front_cmd),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (queue_ready)
    );

    lh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_data  (front_cmd),
        .o_ready (queue_ready),
        .o_valid (queue_valid),
        .o_data  (queue_cmd),
        .i_pop   (back_pop)
    );

    lh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (queue_valid),
        .i_cmd       (queue_cmd),
        .o_cmd_pop   (back_pop),
        .o_bin       (o_bin)
    );

endmodule

`default_nettype wire
